@@ rtl/core/chlp_pkg.sv @@
// ----------------------------------------------------------------------------
// chlp_pkg
// Shared types and constants for the core hotplug load policy block.
// ----------------------------------------------------------------------------
package chlp_pkg;

  // Ring of load samples and core count limits.
  localparam int unsigned RING_DEPTH = 10;
  localparam int unsigned MAX_CORES  = 8;

  // Field widths.
  localparam int unsigned CORE_W  = 4;
  localparam int unsigned RUN_W   = 8;
  localparam int unsigned LOAD_W  = 15;
  localparam int unsigned BASE_W  = 10;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned SQ_W    = 2 * CORE_W;
  localparam int unsigned DPROD_W = BASE_W + SQ_W;
  localparam int unsigned THR_W   = 16;

  // Ring indexing and sum width.
  localparam int unsigned POS_W = $clog2(RING_DEPTH);
  localparam int unsigned SUM_W = LOAD_W + $clog2(RING_DEPTH);

  // Average by reciprocal multiply: exact for every sum below 2**SUM_W.
  localparam int unsigned DIV_SH  = SUM_W + $clog2(RING_DEPTH);
  localparam int unsigned RECIP_W = SUM_W + 2;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SH) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

  // Scale factors and thresholds.
  localparam logic [LOAD_W-1:0] LOAD_SCALE    = LOAD_W'(100);
  localparam logic [THR_W-1:0]  ALL_PER_CORE  = THR_W'(100);
  localparam logic [THR_W-1:0]  UP_PER_CORE   = THR_W'(300);
  localparam logic [THR_W-1:0]  DOWN_PER_CORE = THR_W'(60);
  localparam logic [CORE_W-1:0] BOOST_SINGLE_BELOW = CORE_W'(2);
  localparam logic [CORE_W-1:0] MAX_CORES_C = CORE_W'(MAX_CORES);
  localparam logic [DELAY_W-1:0] DELAY_SAT  = {DELAY_W{1'b1}};

  // Input command codes.
  localparam logic [1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [1:0] CMD_BOOST   = 2'd1;
  localparam logic [1:0] CMD_UNPAUSE = 2'd2;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_ENABLE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN     = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX     = 3'd2;
  localparam logic [IDX_W-1:0] REG_PRESENT = 3'd3;
  localparam logic [IDX_W-1:0] REG_BASE    = 3'd4;

  // Hotplug action codes.
  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_ALL     = 2'd1,
    ACT_ONE     = 2'd2,
    ACT_OFF     = 2'd3
  } chlp_action_t;

  // Configuration register set.
  typedef struct packed {
    logic              enable;
    logic [CORE_W-1:0] min_cores;
    logic [CORE_W-1:0] max_cores;
    logic [CORE_W-1:0] present_cores;
    logic [BASE_W-1:0] base_period;
  } chlp_cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic sum_step;
    logic mul;
    logic commit;
  } chlp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_sample;
    logic sum_last;
  } chlp_sts_t;

endpackage

@@ rtl/core/chlp_ctrl.sv @@
// ----------------------------------------------------------------------------
// chlp_ctrl
// Sequencer for one event: accept, then ring sum and average multiply for a sample, then decision.
// ----------------------------------------------------------------------------
module chlp_ctrl import chlp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  chlp_sts_t sts,
  output chlp_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SUM    = 4'b0010,
    ST_MUL    = 4'b0100,
    ST_DECIDE = 4'b1000
  } chlp_state_t;

  chlp_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  // The result register can take a new beat when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Commands to the datapath.
  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == ST_IDLE) && in_valid;
    cmd.sum_step = (state_r == ST_SUM);
    cmd.mul      = (state_r == ST_MUL);
    cmd.commit   = (state_r == ST_DECIDE) && out_free;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.is_sample ? ST_SUM : ST_DECIDE;
        end
      end
      ST_SUM: begin
        if (sts.sum_last) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result beat valid.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/core/chlp_dp.sv @@
// ----------------------------------------------------------------------------
// chlp_dp
// Load ring, running sum, average, threshold decision and result register.
// ----------------------------------------------------------------------------
module chlp_dp import chlp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  chlp_cfg_t            cfg,
  input  logic                 enable_rise,
  input  chlp_cmd_t            cmd,
  output chlp_sts_t            sts,
  input  logic [1:0]           in_command,
  input  logic [RUN_W-1:0]     in_run_count,
  input  logic [CORE_W-1:0]    in_cores_online,
  input  logic                 in_offline_pending,
  input  logic                 in_suspended,
  output logic [1:0]           out_action,
  output logic                 out_cancel_offline,
  output logic                 out_start_unpause,
  output logic                 out_reschedule,
  output logic [DELAY_W-1:0]   out_next_delay,
  output logic [LOAD_W-1:0]    out_average_load,
  output logic                 out_paused_now,
  output logic                 out_boost_now
);

  // Ring storage and position.
  logic [LOAD_W-1:0] ring_r [RING_DEPTH];
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  idx_r, idx_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [DPROD_W-1:0] dprod_r;

  // Latched event.
  logic [1:0]        command_r;
  logic [CORE_W-1:0] online_r;
  logic              pending_r;
  logic              susp_r;
  logic              sample_r;
  logic [SQ_W-1:0]   sq_r;

  // Policy flags.
  logic paused_r, paused_nxt;
  logic boost_r, boost_nxt;

  // Result register.
  chlp_action_t       action_r, action_nxt;
  logic               cancel_r, cancel_nxt;
  logic               unpause_r, unpause_nxt;
  logic               resched_r, resched_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic [LOAD_W-1:0]  avg_r, avg_nxt;

  // Decision helpers.
  logic [LOAD_W-1:0]  avg;
  logic [THR_W-1:0]   avg_w;
  logic [CORE_W-1:0]  present;
  logic [THR_W-1:0]   thr_all, thr_up, thr_down;
  logic [DELAY_W-1:0] delay_sat;
  logic               room;
  logic               take_sample;

  assign take_sample = (in_command == CMD_SAMPLE) && cfg.enable;

  assign sts.is_sample = take_sample;
  assign sts.sum_last  = (idx_r == POS_W'(RING_DEPTH - 1));

  // Ring write position and sum index.
  always_comb begin
    pos_nxt = pos_r;
    if (cmd.load && take_sample) begin
      pos_nxt = (pos_r == POS_W'(RING_DEPTH - 1)) ? '0 : pos_r + POS_W'(1);
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    sum_nxt = sum_r;
    if (cmd.load) begin
      idx_nxt = '0;
      sum_nxt = '0;
    end else if (cmd.sum_step) begin
      idx_nxt = idx_r + POS_W'(1);
      sum_nxt = sum_r + SUM_W'(ring_r[idx_r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Ring contents; reset clears every entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
    end else if (cmd.load && take_sample) begin
      ring_r[pos_r] <= LOAD_W'(in_run_count) * LOAD_SCALE;
    end
  end

  // Event latch, running sum and the two products.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    sum_r <= sum_nxt;
    if (cmd.load) begin
      command_r <= in_command;
      online_r  <= in_cores_online;
      pending_r <= in_offline_pending;
      susp_r    <= in_suspended;
      sample_r  <= take_sample;
      sq_r      <= SQ_W'(in_cores_online) * SQ_W'(in_cores_online);
    end
    if (cmd.mul) begin
      prod_r  <= PROD_W'(sum_r) * PROD_W'(RECIP);
      dprod_r <= DPROD_W'(cfg.base_period) * DPROD_W'(sq_r);
    end
  end

  // Average, scaled thresholds and the saturated long delay.
  assign avg     = prod_r[DIV_SH +: LOAD_W];
  assign avg_w   = THR_W'(avg);
  assign present = (cfg.present_cores > MAX_CORES_C) ? MAX_CORES_C : cfg.present_cores;
  assign thr_all  = THR_W'(present) * ALL_PER_CORE;
  assign thr_up   = THR_W'(online_r) * UP_PER_CORE;
  assign thr_down = THR_W'(online_r) * DOWN_PER_CORE;
  assign room     = (cfg.max_cores > online_r);
  assign delay_sat = (dprod_r > DPROD_W'(DELAY_SAT)) ? DELAY_SAT : DELAY_W'(dprod_r);

  // Policy decision for the latched event.
  always_comb begin
    paused_nxt  = paused_r;
    boost_nxt   = boost_r;
    action_nxt  = ACT_NONE;
    cancel_nxt  = 1'b0;
    unpause_nxt = 1'b0;
    resched_nxt = 1'b0;
    delay_nxt   = '0;
    avg_nxt     = '0;
    if (sample_r) begin
      avg_nxt = avg;
      priority if (avg_w >= thr_all && online_r < present && room) begin
        paused_nxt = 1'b1;
        cancel_nxt = pending_r;
        action_nxt = ACT_ALL;
      end else if (paused_r) begin
        resched_nxt = 1'b1;
        delay_nxt   = DELAY_W'(cfg.base_period);
      end else if (avg_w >= thr_up && online_r < present && room) begin
        cancel_nxt = pending_r;
        action_nxt = ACT_ONE;
      end else begin
        if (avg_w <= thr_down && cfg.min_cores < online_r) begin
          if (!pending_r) begin
            action_nxt = ACT_OFF;
          end
          boost_nxt = 1'b0;
        end
        resched_nxt = 1'b1;
        delay_nxt   = delay_sat;
      end
    end else if (command_r == CMD_BOOST) begin
      if (cfg.enable && !susp_r && !boost_r && room) begin
        boost_nxt = 1'b1;
        if (online_r < BOOST_SINGLE_BELOW) begin
          cancel_nxt  = 1'b1;
          paused_nxt  = 1'b1;
          action_nxt  = ACT_ONE;
          unpause_nxt = 1'b1;
        end else if (pending_r) begin
          cancel_nxt  = 1'b1;
          paused_nxt  = 1'b1;
          unpause_nxt = 1'b1;
          resched_nxt = 1'b1;
          delay_nxt   = DELAY_W'(cfg.base_period);
        end
      end
    end else if (command_r == CMD_UNPAUSE) begin
      paused_nxt = 1'b0;
    end
  end

  // Flags move only when a result is committed or enable is switched on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paused_r <= 1'b1;
      boost_r  <= 1'b0;
    end else if (enable_rise) begin
      paused_r <= 1'b0;
    end else if (cmd.commit) begin
      paused_r <= paused_nxt;
      boost_r  <= boost_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      action_r  <= action_nxt;
      cancel_r  <= cancel_nxt;
      unpause_r <= unpause_nxt;
      resched_r <= resched_nxt;
      delay_r   <= delay_nxt;
      avg_r     <= avg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_paused_now <= paused_nxt;
      out_boost_now  <= boost_nxt;
    end
  end

  assign out_action         = action_r;
  assign out_cancel_offline = cancel_r;
  assign out_start_unpause  = unpause_r;
  assign out_reschedule     = resched_r;
  assign out_next_delay     = delay_r;
  assign out_average_load   = avg_r;

endmodule

@@ rtl/core/core_hotplug_load_policy.sv @@
// ----------------------------------------------------------------------------
// core_hotplug_load_policy
// Load-driven core hotplug decision block: top level with register file.
// ----------------------------------------------------------------------------
// One event is taken at a time and gives one result beat. An enabled load
// sample passes from acceptance through ST_SUM, ST_MUL and ST_DECIDE before
// the next acceptance: the RING_DEPTH entries are summed one entry per
// cycle through a single adder, then ST_MUL multiplies the sum by the
// reciprocal of the ring depth and ST_DECIDE makes the decision. Boost
// pulses, unpause ticks, unused commands and samples while disabled go
// straight to ST_DECIDE. The result sits in an output register, so the next event is
// accepted while a finished beat is still stalled, unless a second result
// is ready before the first has been taken.
module core_hotplug_load_policy import chlp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // Event channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_command,
  input  logic [RUN_W-1:0]     in_run_count,
  input  logic [CORE_W-1:0]    in_cores_online,
  input  logic                 in_offline_pending,
  input  logic                 in_suspended,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_action,
  output logic                 out_cancel_offline,
  output logic                 out_start_unpause,
  output logic                 out_reschedule,
  output logic [DELAY_W-1:0]   out_next_delay,
  output logic [LOAD_W-1:0]    out_average_load,
  output logic                 out_paused_now,
  output logic                 out_boost_now
);

  chlp_cfg_t cfg_r, cfg_nxt;
  logic      enable_rise;
  chlp_cmd_t cmd;
  chlp_sts_t sts;

  // Register writes; indexes past the list are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:  cfg_nxt.enable        = cfg_wdata[0];
        REG_MIN:     cfg_nxt.min_cores     = cfg_wdata[CORE_W-1:0];
        REG_MAX:     cfg_nxt.max_cores     = cfg_wdata[CORE_W-1:0];
        REG_PRESENT: cfg_nxt.present_cores = cfg_wdata[CORE_W-1:0];
        REG_BASE:    cfg_nxt.base_period   = cfg_wdata[BASE_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  // Switching the policy on clears the paused flag.
  assign enable_rise = cfg_we && (cfg_index == REG_ENABLE) && cfg_wdata[0] && !cfg_r.enable;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable        <= 1'b0;
      cfg_r.min_cores     <= CORE_W'(2);
      cfg_r.max_cores     <= CORE_W'(2);
      cfg_r.present_cores <= CORE_W'(4);
      cfg_r.base_period   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  chlp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  chlp_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .enable_rise        (enable_rise),
    .cmd                (cmd),
    .sts                (sts),
    .in_command         (in_command),
    .in_run_count       (in_run_count),
    .in_cores_online    (in_cores_online),
    .in_offline_pending (in_offline_pending),
    .in_suspended       (in_suspended),
    .out_action         (out_action),
    .out_cancel_offline (out_cancel_offline),
    .out_start_unpause  (out_start_unpause),
    .out_reschedule     (out_reschedule),
    .out_next_delay     (out_next_delay),
    .out_average_load   (out_average_load),
    .out_paused_now     (out_paused_now),
    .out_boost_now      (out_boost_now)
  );

endmodule
